// ===== rtl/core/fsr_pkg.sv =====
`timescale 1ns / 1ps
// package for the fiat-shamir round block
// holds the default word width and the register index codes

package fsr_pkg;

   localparam int WORD_WIDTH_DEFAULT = 32;

   typedef enum logic [0:0] {
      CSR_MODULUS = 1'b0,
      CSR_SECRET  = 1'b1
   } csr_index_type;

endpackage

// ===== rtl/core/fsr_datapath.sv =====
`timescale 1ns / 1ps
// bit-per-stage pipeline: reduce x and s, then x*x, x*s, s*s, then y*y and a*v mod n
// depends on fsr_pkg only for the default WORD_WIDTH; widths follow WORD_WIDTH

module fsr_datapath #(
   parameter int WORD_WIDTH = fsr_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [WORD_WIDTH-1:0] in_x,
   input  logic                  in_e,
   input  logic                  in_last,
   input  logic [WORD_WIDTH-1:0] secret,
   input  logic [WORD_WIDTH-1:0] modulus,
   output logic                  out_valid,
   output logic [WORD_WIDTH-1:0] out_witness,
   output logic [WORD_WIDTH-1:0] out_response,
   output logic [WORD_WIDTH-1:0] out_public_key,
   output logic                  out_ok,
   output logic                  out_last
);
   import fsr_pkg::*;

   localparam int W      = WORD_WIDTH;
   localparam int STAGES = 3 * W;

   typedef struct packed {
      logic         e;
      logic         last;
      logic         ok;
      logic [W-1:0] w0;
      logic [W-1:0] w1;
      logic [W-1:0] w2;
      logic [W-1:0] a0;
      logic [W-1:0] a1;
      logic [W-1:0] a2;
   } stage_type;

   function automatic logic [W-1:0] red_step(input logic [W-1:0] r, input logic b,
                                             input logic [W-1:0] n);
      logic [W:0] t;
      t = {r, b};
      if (t >= {1'b0, n}) t = t - {1'b0, n};
      return t[W-1:0];
   endfunction

   function automatic logic [W-1:0] mul_step(input logic [W-1:0] acc, input logic b,
                                             input logic [W-1:0] base,
                                             input logic [W-1:0] n);
      logic [W:0] d;
      logic [W:0] s;
      d = {acc, 1'b0};
      if (d >= {1'b0, n}) d = d - {1'b0, n};
      s = {1'b0, d[W-1:0]};
      if (b) s = s + {1'b0, base};
      if (s >= {1'b0, n}) s = s - {1'b0, n};
      return s[W-1:0];
   endfunction

   logic      vld_ff [0:STAGES];
   stage_type stg_ff [0:STAGES];
   stage_type stg_in;

   always_comb begin
      stg_in      = '0;
      stg_in.e    = in_e;
      stg_in.last = in_last;
      stg_in.w0   = in_x;
      stg_in.w2   = secret;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_ff[0] <= stg_in;
      end
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int PH = k / W;
      localparam int BP = W - 1 - (k % W);
      stage_type cur;
      stage_type nx;

      assign cur = stg_ff[k];

      if (PH == 0) begin : g_reduce
         always_comb begin
            nx    = cur;
            nx.a0 = red_step(cur.a0, cur.w0[BP], modulus);
            nx.a2 = red_step(cur.a2, cur.w2[BP], modulus);
            if (BP == 0) begin
               nx.w0 = nx.a0;
               nx.w2 = nx.a2;
               nx.a0 = '0;
               nx.a1 = '0;
               nx.a2 = '0;
            end
         end
      end else if (PH == 1) begin : g_first
         always_comb begin
            nx    = cur;
            nx.a1 = mul_step(cur.a1, cur.w0[BP], cur.w0, modulus);
            nx.a0 = mul_step(cur.a0, cur.w2[BP], cur.w0, modulus);
            nx.a2 = mul_step(cur.a2, cur.w2[BP], cur.w2, modulus);
            if (BP == 0) begin
               nx.w0 = cur.e ? nx.a0 : cur.w0;
               nx.w1 = nx.a1;
               nx.w2 = nx.a2;
               nx.a0 = '0;
               nx.a1 = '0;
               nx.a2 = '0;
            end
         end
      end else begin : g_check
         always_comb begin
            nx    = cur;
            nx.a0 = mul_step(cur.a0, cur.w0[BP], cur.w0, modulus);
            nx.a1 = mul_step(cur.a1, cur.w1[BP], cur.w2, modulus);
            if (BP == 0) begin
               nx.ok = (modulus != '0) && (nx.a0 == (cur.e ? nx.a1 : cur.w1));
               if (modulus == '0) begin
                  nx.w0 = '0;
                  nx.w1 = '0;
                  nx.w2 = '0;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            stg_ff[k+1] <= nx;
         end
      end
   end

   assign out_valid      = vld_ff[STAGES];
   assign out_witness    = stg_ff[STAGES].w1;
   assign out_response   = stg_ff[STAGES].w0;
   assign out_public_key = stg_ff[STAGES].w2;
   assign out_ok         = stg_ff[STAGES].ok;
   assign out_last       = stg_ff[STAGES].last;

endmodule

// ===== rtl/core/fiat_shamir_round.sv =====
`timescale 1ns / 1ps
// One Fiat-Shamir identification round per request: from commitment x and challenge e it
// returns witness x^2 mod n, response (x or x*s mod n), public key s^2 mod n and the verdict.
// The datapath is a pipeline with one bit step per stage, 3*WORD_WIDTH+1 register stages
// (97 at 32 bits): WORD_WIDTH stages reduce x and s, WORD_WIDTH stages form the three
// first products, WORD_WIDTH stages form y^2 and a*v. A request enters every cycle unless
// the pipe is held; the whole pipe holds while a response waits.
// Depends on fsr_pkg and fsr_datapath.

module fiat_shamir_round #(
   parameter int WORD_WIDTH = fsr_pkg::WORD_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [WORD_WIDTH-1:0] req_commitment,
   input  logic                  req_challenge,
   input  logic                  req_last_round,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_WIDTH-1:0] rsp_witness,
   output logic [WORD_WIDTH-1:0] rsp_response,
   output logic [WORD_WIDTH-1:0] rsp_public_key,
   output logic                  rsp_accepted,
   output logic                  rsp_last,
   input  logic                  csr_write,
   input  fsr_pkg::csr_index_type csr_index,
   input  logic [WORD_WIDTH-1:0] csr_wdata
);
   import fsr_pkg::*;

   logic [WORD_WIDTH-1:0] modulus_ff;
   logic [WORD_WIDTH-1:0] secret_ff;
   logic                  adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= WORD_WIDTH'(2);
         secret_ff  <= WORD_WIDTH'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS: modulus_ff <= csr_wdata;
            CSR_SECRET:  secret_ff  <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // pipe moves whenever the output stage is empty or being taken
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   fsr_datapath #(
      .WORD_WIDTH(WORD_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .in_x          (req_commitment),
      .in_e          (req_challenge),
      .in_last       (req_last_round),
      .secret        (secret_ff),
      .modulus       (modulus_ff),
      .out_valid     (rsp_valid),
      .out_witness   (rsp_witness),
      .out_response  (rsp_response),
      .out_public_key(rsp_public_key),
      .out_ok        (rsp_accepted),
      .out_last      (rsp_last)
   );

   a_zero_modulus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && modulus_ff == '0 |->
         !rsp_accepted && rsp_witness == '0 && rsp_response == '0 && rsp_public_key == '0)
      else $error("zero modulus response not cleared");

   a_unit_modulus: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && modulus_ff == WORD_WIDTH'(1) |-> rsp_accepted)
      else $error("unit modulus round rejected");

   a_residues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && modulus_ff != '0 |->
         rsp_witness < modulus_ff && rsp_response < modulus_ff &&
         rsp_public_key < modulus_ff)
      else $error("residue not below modulus");

endmodule
